FILE: design/keyed_record_table_macros.svh
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// condition that must hold at every edge outside reset
`define KRT_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("krt check failed");

// trigger in one cycle implies result in the next
`define KRT_CHECK_NEXT(lbl, trig, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) \
    else $error("krt sequence check failed");

`endif

FILE: design/krt_pkg.sv
package krt_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int PHONE_W  = 31;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_W    = 7;
  localparam int CAP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_ADDED    = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_FULL     = 3'd4,
    ST_REMOVED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_REQ,
    SRC_RAM
  } res_src_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic act;
    logic finish;
  } krt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } krt_stat_t;

endpackage

FILE: design/krt_interfaces.sv
interface krt_req_if;
  logic                          valid;
  logic                          ready;
  logic [krt_pkg::OP_W-1:0]      opcode;
  logic [krt_pkg::KEY_W-1:0]     student_key;
  logic [krt_pkg::PHONE_W-1:0]   phone_value;
  logic [krt_pkg::NAME_W-1:0]    name_word;

  modport source (output valid, opcode, student_key, phone_value, name_word, input ready);
  modport sink   (input valid, opcode, student_key, phone_value, name_word, output ready);
endinterface

interface krt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [krt_pkg::STATUS_W-1:0]      status;
  logic [krt_pkg::SLOT_OUT_W-1:0]    slot_index;
  logic [krt_pkg::PHONE_W-1:0]       phone_out;
  logic [krt_pkg::NAME_W-1:0]        name_out;
  logic [krt_pkg::COUNT_OUT_W-1:0]   entry_count;

  modport source (output valid, status, slot_index, phone_out, name_out, entry_count,
                  input ready);
  modport sink   (input valid, status, slot_index, phone_out, name_out, entry_count,
                  output ready);
endinterface

interface krt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [krt_pkg::CFG_W-1:0]   capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

FILE: design/krt_ram.sv
module krt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/krt_ctrl.sv
module krt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  krt_pkg::krt_stat_t stat,
  output krt_pkg::krt_cmd_t  cmd
);

  krt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= krt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      krt_pkg::S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = krt_pkg::S_SCAN;
        end
      end
      krt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = krt_pkg::S_ACT;
        end
      end
      krt_pkg::S_ACT: begin
        cmd.act    = 1'b1;
        state_next = krt_pkg::S_FINISH;
      end
      krt_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        if (!stat.out_busy) begin
          state_next = krt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = krt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/krt_dp.sv
`include "keyed_record_table_macros.svh"

module krt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  krt_pkg::krt_cmd_t                   cmd,
  output krt_pkg::krt_stat_t                  stat,
  input  logic [krt_pkg::OP_W-1:0]            opcode,
  input  logic [krt_pkg::KEY_W-1:0]           student_key,
  input  logic [krt_pkg::PHONE_W-1:0]         phone_value,
  input  logic [krt_pkg::NAME_W-1:0]          name_word,
  input  logic                                cfg_valid,
  input  logic [krt_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [krt_pkg::STATUS_W-1:0]        status,
  output logic [krt_pkg::SLOT_OUT_W-1:0]      slot_index,
  output logic [krt_pkg::PHONE_W-1:0]         phone_out,
  output logic [krt_pkg::NAME_W-1:0]          name_out,
  output logic [krt_pkg::COUNT_OUT_W-1:0]     entry_count
);

  // latched request
  logic [krt_pkg::OP_W-1:0]    op_r;
  logic [krt_pkg::KEY_W-1:0]   key_r;
  logic [krt_pkg::PHONE_W-1:0] phone_r;
  logic [krt_pkg::NAME_W-1:0]  name_r;

  // table state
  logic [krt_pkg::CAPACITY-1:0] slot_valid;
  logic [krt_pkg::CNT_W-1:0]    count;
  logic [krt_pkg::CFG_W-1:0]    cap;

  // scan state
  logic [krt_pkg::CNT_W-1:0]  idx;
  logic [krt_pkg::SLOT_W-1:0] cmp_idx;
  logic                       cmp_vld;
  logic                       hit;
  logic [krt_pkg::SLOT_W-1:0] hit_idx;
  logic                       free_found;
  logic [krt_pkg::SLOT_W-1:0] free_idx;

  // result staging
  krt_pkg::status_t           res_status;
  logic [krt_pkg::SLOT_W-1:0] res_slot;
  krt_pkg::res_src_t          res_src;

  logic [krt_pkg::CAP_W-1:0]   cap_ext;
  logic [krt_pkg::CAP_W-1:0]   eff_cap;
  logic                        idx_live;
  logic                        hit_now;
  logic                        add_ok;
  logic                        key_re;
  logic                        key_we;
  logic                        rec_we;
  logic                        rec_re;
  logic [krt_pkg::SLOT_W-1:0]  waddr;
  logic [krt_pkg::KEY_W-1:0]   key_rdata;
  logic [krt_pkg::PHONE_W-1:0] phone_rdata;
  logic [krt_pkg::NAME_W-1:0]  name_rdata;

  assign cap_ext  = krt_pkg::CAP_W'(cap);
  assign eff_cap  = (cap_ext > krt_pkg::CAP_W'(krt_pkg::CAPACITY)) ?
                    krt_pkg::CAP_W'(krt_pkg::CAPACITY) : cap_ext;
  assign idx_live = (idx < krt_pkg::CNT_W'(krt_pkg::CAPACITY));
  assign hit_now  = cmd.scan && cmp_vld && slot_valid[cmp_idx] && (key_rdata == key_r);
  assign add_ok   = free_found && (krt_pkg::CAP_W'(count) < eff_cap);

  assign stat.scan_done = hit_now || (cmp_vld && !idx_live);
  assign stat.out_busy  = rsp_valid && !rsp_ready;

  assign key_re = cmd.scan && !hit && idx_live;
  assign key_we = cmd.act && (op_r == krt_pkg::OP_ADD) && !hit && add_ok;
  assign rec_we = cmd.act && (op_r == krt_pkg::OP_ADD) && (hit || add_ok);
  assign rec_re = cmd.act && hit && (op_r != krt_pkg::OP_ADD);
  assign waddr  = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= krt_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode;
      key_r   <= student_key;
      phone_r <= phone_value;
      name_r  <= name_word;
    end
  end

  // linear scan: one key read per cycle, compare in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      idx        <= '0;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan && !hit) begin
      if (hit_now) begin
        hit     <= 1'b1;
        hit_idx <= cmp_idx;
      end
      if (idx_live) begin
        cmp_idx <= idx[krt_pkg::SLOT_W-1:0];
        cmp_vld <= 1'b1;
        idx     <= idx + 1'b1;
        if (!free_found && !slot_valid[idx[krt_pkg::SLOT_W-1:0]] &&
            (krt_pkg::CAP_W'(idx) < eff_cap)) begin
          free_found <= 1'b1;
          free_idx   <= idx[krt_pkg::SLOT_W-1:0];
        end
      end else begin
        cmp_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (cmd.act) begin
      if (key_we) begin
        slot_valid[free_idx] <= 1'b1;
        count                <= count + 1'b1;
      end else if ((op_r == krt_pkg::OP_REMOVE) && hit) begin
        slot_valid[hit_idx] <= 1'b0;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      res_status <= krt_pkg::ST_NOTFOUND;
      res_slot   <= '0;
      res_src    <= krt_pkg::SRC_ZERO;
      case (op_r)
        krt_pkg::OP_ADD: begin
          if (hit) begin
            res_status <= krt_pkg::ST_UPDATED;
            res_slot   <= hit_idx;
            res_src    <= krt_pkg::SRC_REQ;
          end else if (add_ok) begin
            res_status <= krt_pkg::ST_ADDED;
            res_slot   <= free_idx;
            res_src    <= krt_pkg::SRC_REQ;
          end else begin
            res_status <= krt_pkg::ST_FULL;
          end
        end
        krt_pkg::OP_REMOVE: begin
          if (hit) begin
            res_status <= krt_pkg::ST_REMOVED;
            res_slot   <= hit_idx;
            res_src    <= krt_pkg::SRC_RAM;
          end
        end
        default: begin
          if (hit) begin
            res_status <= krt_pkg::ST_FOUND;
            res_slot   <= hit_idx;
            res_src    <= krt_pkg::SRC_RAM;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish && !stat.out_busy) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !stat.out_busy) begin
      status      <= res_status;
      slot_index  <= krt_pkg::SLOT_OUT_W'(res_slot);
      entry_count <= krt_pkg::COUNT_OUT_W'(count);
      case (res_src)
        krt_pkg::SRC_REQ: begin
          phone_out <= phone_r;
          name_out  <= name_r;
        end
        krt_pkg::SRC_RAM: begin
          phone_out <= phone_rdata;
          name_out  <= name_rdata;
        end
        default: begin
          phone_out <= '0;
          name_out  <= '0;
        end
      endcase
    end
  end

  krt_ram #(.WIDTH(krt_pkg::KEY_W), .DEPTH(krt_pkg::CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_idx),
    .wdata (key_r),
    .re    (key_re),
    .raddr (idx[krt_pkg::SLOT_W-1:0]),
    .rdata (key_rdata)
  );

  krt_ram #(.WIDTH(krt_pkg::PHONE_W), .DEPTH(krt_pkg::CAPACITY)) u_phone_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (waddr),
    .wdata (phone_r),
    .re    (rec_re),
    .raddr (hit_idx),
    .rdata (phone_rdata)
  );

  krt_ram #(.WIDTH(krt_pkg::NAME_W), .DEPTH(krt_pkg::CAPACITY)) u_name_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (waddr),
    .wdata (name_r),
    .re    (rec_re),
    .raddr (hit_idx),
    .rdata (name_rdata)
  );

  `KRT_CHECK(a_count_range, count <= krt_pkg::CNT_W'(krt_pkg::CAPACITY))
  `KRT_CHECK(a_hit_is_valid, !(cmd.act && hit) || slot_valid[hit_idx])
  `KRT_CHECK_NEXT(a_add_sets_valid, key_we, slot_valid[$past(free_idx)])
  `KRT_CHECK_NEXT(a_busy_holds, stat.out_busy, rsp_valid)

endmodule

FILE: design/keyed_record_table.sv
// Keyed record table, 64 slots, linear search through the key memory.
// Requests are handled one at a time: a new request is accepted only after the previous
// result has been loaded into the output register, which waits while a response is stalled.
// Reset (rst, synchronous): clears all valid bits, the entry count and the output
// valid, sets capacity_in_use to 64; record memories are not cleared.
module keyed_record_table (
  input  logic       clk,
  input  logic       rst,
  krt_req_if.sink    req,
  krt_rsp_if.source  rsp,
  krt_cfg_if.sink    cfg
);

  krt_pkg::krt_cmd_t  cmd;
  krt_pkg::krt_stat_t stat;

  assign cfg.ready = !rst;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  krt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (req.opcode),
    .student_key (req.student_key),
    .phone_value (req.phone_value),
    .name_word   (req.name_word),
    .cfg_valid   (cfg.valid),
    .cfg_data    (cfg.capacity_in_use),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .status      (rsp.status),
    .slot_index  (rsp.slot_index),
    .phone_out   (rsp.phone_out),
    .name_out    (rsp.name_out),
    .entry_count (rsp.entry_count)
  );

endmodule
